// ===== sv/tows_pkg.sv =====
// Package for the temperature outlier window statistics block.
// Holds widths, status and opcode codes, and register indexes; no dependencies.
package tows_pkg;

  localparam int unsigned WindowDepth = 4096;
  localparam int unsigned AddrW = $clog2(WindowDepth);
  localparam int unsigned CountW = $clog2(WindowDepth + 1);
  localparam int unsigned SumW = 16 + CountW;
  localparam int unsigned OffsetF = 512;

  localparam logic [2:0] StStoredValid = 3'd0;
  localparam logic [2:0] StStoredInvalid = 3'd1;
  localparam logic [2:0] StReportOk = 3'd2;
  localparam logic [2:0] StStandby = 3'd3;
  localparam logic [2:0] StNoData = 3'd4;

  localparam logic OpStore = 1'b0;
  localparam logic OpReport = 1'b1;

  localparam logic [2:0] RegFahrenheit = 3'd0;
  localparam logic [2:0] RegStandby = 3'd1;
  localparam logic [2:0] RegHighLimit = 3'd2;
  localparam logic [2:0] RegLowLimit = 3'd3;
  localparam logic [2:0] RegMaxStep = 3'd4;

  typedef struct packed {
    logic fahrenheit_mode;
    logic standby_mode;
    logic signed [15:0] high_limit;
    logic signed [15:0] low_limit;
    logic [14:0] max_step;
  } cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== sv/temperature_outlier_window_stats.sv =====
// Top level of the temperature outlier window statistics block.
// Depends on tows_pkg, tows_store and tows_div.
//
// Usage: pulse start with opcode and sample_value while busy is low. Opcode 0
// stores one reading (converted from Fahrenheit when fahrenheit_mode is set),
// opcode 1 returns a report over the window. Exactly one result beat follows
// each accepted item, shown on the result ports for one cycle with done high;
// the receiver cannot stall. Registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, as
// the block itself does not enforce it.
// A store walks the filled entries newest first to find the newest normal
// one. A report outside standby walks them twice (once for the newest normal
// entry, once for sum, minimum and maximum) then, if any entry is valid, runs
// the serial divider for the average. Unit conversions divide by 9 or 5
// through a reciprocal multiply. Entries are read through the single memory
// read port; a full window holds 4096 entries.
// One item at a time: busy stays high for the whole item. Synchronous reset
// empties the window (fill count zero) and loads the register defaults;
// memory contents are not cleared.
module temperature_outlier_window_stats (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic opcode,
  input  logic signed [15:0] sample_value,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic done,
  output logic [2:0] status,
  output logic signed [15:0] current_value,
  output logic current_present,
  output logic signed [15:0] average_value,
  output logic signed [15:0] minimum_value,
  output logic signed [15:0] maximum_value
);
  import tows_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_STATS, S_STATS_WAIT,
    S_DIV, S_OUT_CUR, S_OUT_AVG, S_OUT_MIN, S_OUT_MAX, S_FINISH
  } state_t;

  state_t state;
  cfg_t cfg;

  logic [AddrW-1:0]  write_position;
  logic [CountW-1:0] filled_count;
  logic [CountW-1:0] k;
  logic op;
  logic signed [15:0] t;
  logic has_last;
  logic signed [15:0] last;
  logic signed [SumW-1:0] sum;
  logic [CountW-1:0] count;
  logic signed [15:0] mn, mx, avg;
  logic [AddrW-1:0] raddr;
  logic [16:0] rdata;
  logic we;
  logic [16:0] wdata;
  logic div_go, div_done;
  logic signed [SumW-1:0] div_a, div_q;
  logic [SumW-1:0] div_b;
  logic conv_pending;
  logic signed [15:0] conv_in;

  // Shared multiply by constant; result registered before the division.
  logic signed [31:0] prod;
  always_comb begin
    if (cfg.fahrenheit_mode && state == S_CONV)
      prod = (32'(t) - 32'sd512) * 32'sd5;
    else
      prod = 32'(conv_in) * 32'sd9;
  end

  // Divide by 9 or 5: registered magnitude times a scaled reciprocal.
  logic        rc_go, rc_done, rc_by5, rc_neg;
  logic [18:0] rc_mag;
  logic [19:0] rc_recip;
  logic [38:0] rc_prod;
  logic [16:0] rc_quo;
  logic signed [31:0] rc_q;
  assign rc_recip = rc_by5 ? 20'd838861 : 20'd233017;
  assign rc_prod = 39'(rc_mag) * 39'(rc_recip);
  assign rc_quo = rc_by5 ? rc_prod[38:22] : rc_prod[37:21];

  logic valid_e;
  logic signed [15:0] val_e;
  assign valid_e = rdata[16];
  assign val_e = rdata[15:0];

  logic signed [16:0] diff;
  assign diff = 17'(last) - 17'(t);
  logic [16:0] adiff;
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);

  tows_store u_store (
    .clk(clk), .we(we), .waddr(write_position), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  tows_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      write_position <= '0;
      filled_count <= '0;
      cfg.fahrenheit_mode <= 1'b0;
      cfg.standby_mode <= 1'b0;
      cfg.high_limit <= 16'sd960;
      cfg.low_limit <= 16'sd160;
      cfg.max_step <= 15'd160;
      we <= 1'b0;
      div_go <= 1'b0;
      conv_pending <= 1'b0;
      rc_go <= 1'b0;
      rc_done <= 1'b0;
    end else begin
      done <= 1'b0;
      we <= 1'b0;
      div_go <= 1'b0;
      rc_go <= 1'b0;
      rc_done <= 1'b0;
      if (rc_go) begin
        rc_q <= rc_neg ? -32'(rc_quo) : 32'(rc_quo);
        rc_done <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          RegFahrenheit: cfg.fahrenheit_mode <= cfg_data[0];
          RegStandby:    cfg.standby_mode <= cfg_data[0];
          RegHighLimit:  cfg.high_limit <= cfg_data;
          RegLowLimit:   cfg.low_limit <= cfg_data;
          RegMaxStep:    cfg.max_step <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            op <= opcode;
            t <= sample_value;
            conv_pending <= 1'b0;
            state <= S_CONV;
          end
        end
        // F to C: multiply now, divide by 9 in the reciprocal unit.
        S_CONV: begin
          if (op == OpStore && cfg.fahrenheit_mode && !conv_pending) begin
            rc_mag <= prod[31] ? 19'(-prod) : 19'(prod);
            rc_neg <= prod[31];
            rc_by5 <= 1'b0;
            rc_go <= 1'b1;
            conv_pending <= 1'b1;
          end else if (op == OpStore && cfg.fahrenheit_mode) begin
            if (rc_done) begin
              t <= sat16(rc_q);
              conv_pending <= 1'b0;
              k <= '0;
              has_last <= 1'b0;
              last <= '0;
              raddr <= write_position - 1'b1;
              state <= S_SCAN;
            end
          end else begin
            k <= '0;
            has_last <= 1'b0;
            last <= '0;
            raddr <= write_position - 1'b1;
            state <= S_SCAN;
          end
        end
        // Walk newest first; read data is registered and lands in the cycle after the address.
        S_SCAN: begin
          if (k == filled_count) state <= S_DECIDE;
          else state <= S_SCAN_WAIT;
        end
        S_SCAN_WAIT: begin
          if (valid_e && val_e > cfg.low_limit && val_e < cfg.high_limit) begin
            has_last <= 1'b1;
            last <= val_e;
            state <= S_DECIDE;
          end else begin
            k <= k + 1'b1;
            raddr <= raddr - 1'b1;
            state <= S_SCAN;
          end
        end
        S_DECIDE: begin
          if (op == OpStore) begin
            logic ok;
            ok = !(t > cfg.high_limit) && !cfg.standby_mode &&
                 !(has_last && adiff > 17'(cfg.max_step));
            wdata <= {ok, t};
            we <= 1'b1;
            status <= ok ? StStoredValid : StStoredInvalid;
            current_value <= '0;
            current_present <= 1'b0;
            average_value <= '0;
            minimum_value <= '0;
            maximum_value <= '0;
            state <= S_FINISH;
          end else if (cfg.standby_mode) begin
            status <= StStandby;
            current_value <= '0;
            current_present <= 1'b0;
            average_value <= '0;
            minimum_value <= '0;
            maximum_value <= '0;
            state <= S_FINISH;
          end else begin
            k <= '0;
            raddr <= '0;
            sum <= '0;
            count <= '0;
            mn <= 16'sh7fff;
            mx <= 16'sh8000;
            state <= S_STATS;
          end
        end
        S_STATS: begin
          if (k == filled_count) begin
            if (count == '0) begin
              status <= StNoData;
              current_value <= '0;
              current_present <= 1'b0;
              average_value <= '0;
              minimum_value <= '0;
              maximum_value <= '0;
              state <= S_FINISH;
            end else begin
              div_a <= sum;
              div_b <= SumW'(count);
              div_go <= 1'b1;
              state <= S_DIV;
            end
          end else begin
            state <= S_STATS_WAIT;
          end
        end
        S_STATS_WAIT: begin
          if (valid_e) begin
            sum <= sum + SumW'(val_e);
            count <= count + 1'b1;
            if (val_e < mn) mn <= val_e;
            if (val_e > mx) mx <= val_e;
          end
          k <= k + 1'b1;
          raddr <= raddr + 1'b1;
          state <= S_STATS;
        end
        S_DIV: begin
          if (div_done) begin
            avg <= div_q[15:0];
            status <= StReportOk;
            current_present <= has_last;
            conv_in <= last;
            conv_pending <= 1'b0;
            state <= S_OUT_CUR;
          end
        end
        // In F mode, C to F for each output: multiply by 9, divide by 5, add offset.
        S_OUT_CUR, S_OUT_AVG, S_OUT_MIN, S_OUT_MAX: begin
          if (!cfg.fahrenheit_mode) begin
            unique case (state)
              S_OUT_CUR: begin
                current_value <= has_last ? last : 16'sd0;
                conv_in <= avg;
                state <= S_OUT_AVG;
              end
              S_OUT_AVG: begin
                average_value <= avg; conv_in <= mn; state <= S_OUT_MIN;
              end
              S_OUT_MIN: begin
                minimum_value <= mn; conv_in <= mx; state <= S_OUT_MAX;
              end
              default: begin
                maximum_value <= mx; state <= S_FINISH;
              end
            endcase
          end else if (!conv_pending) begin
            rc_mag <= prod[31] ? 19'(-prod) : 19'(prod);
            rc_neg <= prod[31];
            rc_by5 <= 1'b1;
            rc_go <= 1'b1;
            conv_pending <= 1'b1;
          end else if (rc_done) begin
            logic signed [15:0] f;
            f = sat16(rc_q + 32'sd512);
            conv_pending <= 1'b0;
            unique case (state)
              S_OUT_CUR: begin
                current_value <= has_last ? f : 16'sd0;
                conv_in <= avg;
                state <= S_OUT_AVG;
              end
              S_OUT_AVG: begin
                average_value <= f; conv_in <= mn; state <= S_OUT_MIN;
              end
              S_OUT_MIN: begin
                minimum_value <= f; conv_in <= mx; state <= S_OUT_MAX;
              end
              default: begin
                maximum_value <= f; state <= S_FINISH;
              end
            endcase
          end
        end
        S_FINISH: begin
          if (op == OpStore) begin
            write_position <= write_position + 1'b1;
            if (filled_count != CountW'(WindowDepth)) filled_count <= filled_count + 1'b1;
          end
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/tows_div.sv =====
// Restoring divider, one quotient bit per cycle, signed truncating.
// Depends on tows_pkg.
module tows_div (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic signed [tows_pkg::SumW-1:0] dividend,
  input  logic [tows_pkg::SumW-1:0] divisor,
  output logic done,
  output logic signed [tows_pkg::SumW-1:0] quotient
);
  import tows_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0] rem;
  logic [SumW-1:0] quo;
  logic [SumW-1:0] dvs;
  logic            neg;
  logic [StepW-1:0] step;
  logic            running;
  logic [SumW:0]   trial;

  assign trial = {rem, quo[SumW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        neg <= dividend[SumW-1];
        quo <= dividend[SumW-1] ? SumW'(-dividend) : dividend;
        rem <= '0;
        dvs <= divisor;
        step <= StepW'(SumW);
      end else if (running) begin
        if (trial[SumW]) begin
          rem <= {rem[SumW-2:0], quo[SumW-1]};
          quo <= {quo[SumW-2:0], 1'b0};
        end else begin
          rem <= trial[SumW-1:0];
          quo <= {quo[SumW-2:0], 1'b1};
        end
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -quo : quo;
endmodule

// ===== sv/tows_store.sv =====
// Sample ring memory: 16 bit Celsius value plus valid bit per entry.
// Depends on tows_pkg.
module tows_store (
  input  logic clk,
  input  logic we,
  input  logic [tows_pkg::AddrW-1:0] waddr,
  input  logic [16:0] wdata,
  input  logic [tows_pkg::AddrW-1:0] raddr,
  output logic [16:0] rdata
);
  import tows_pkg::*;

  logic [16:0] mem [WindowDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/tows_checker.sv =====
// Port-level checker for the temperature outlier window statistics block.
// Depends on tows_pkg; bound to the top level below.
module tows_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [2:0] status,
  input logic current_present,
  input logic signed [15:0] current_value
);
  import tows_pkg::*;

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("done without busy item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item not marked busy");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= StNoData) else $error("status code out of range");

  a_no_cur: assert property (@(posedge clk) disable iff (rst)
    done && !current_present |-> current_value == 16'sd0)
    else $error("current value without present flag");
endmodule

bind temperature_outlier_window_stats tows_checker u_tows_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .current_present(current_present),
  .current_value(current_value)
);
